[sv/pbms_pkg.sv]
// Operation codes, field widths and stream packing constants for the packed bit matrix store.
package pbms_pkg;

    localparam int FUNC_W   = 3;
    localparam int NDIM_W   = 5;
    localparam int INDEX_W  = 4;
    localparam int DIMOUT_W = 5;

    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 8;
    localparam int M_TDATA_W = 8;

    localparam logic [FUNC_W-1:0] OP_SIZE   = 3'd0;
    localparam logic [FUNC_W-1:0] OP_GROW   = 3'd1;
    localparam logic [FUNC_W-1:0] OP_REMOVE = 3'd2;
    localparam logic [FUNC_W-1:0] OP_READ   = 3'd3;
    localparam logic [FUNC_W-1:0] OP_WRITE  = 3'd4;

    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_IGNORED = 1'b1;

endpackage

[sv/packed_bit_matrix_store.sv]
// Top level of the packed bit matrix store: operation sequencer around a one-bit matrix memory.
//
// Input channel s_*: one item per operation; s_tuser carries the operation code and s_tdata
// its operands. Result channel m_*: exactly one item per accepted input item, holding the bit
// read, the dimension after the operation and a done/ignored status.
// The matrix lives bit by bit in a MAX_DIM*MAX_DIM entry memory with a registered read port;
// one sequencer walks it one bit per step, so the memory port sets the time of each operation.
// Memory work per operation (d = dimension before the operation):
//   size   : every bit of the memory rewritten as one
//   grow   : all (d+1)^2 positions of the new matrix written, the d^2 old bits copied
//   remove : all d^2 old bits visited, the (d-1)^2 kept bits copied
//   read and write: one bit accessed; ignored operations: no memory access.
// The block takes one item at a time: s_tready is high only while no operation is in work.
// The result sits in an output register, so the next item is accepted while it waits; a stalled
// m_tready holds the finished result of the following item until the register frees up.
// Reset (aresetn low, synchronous) empties the matrix (dimension 0) and clears both channels;
// the memory needs no clearing since every bit is written by size or grow before it is read.
module packed_bit_matrix_store #(
    parameter int MAX_DIM = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [4:0] new_dimension, [8:5] row_index, [12:9] col_index, [13] bit_value
    input  logic [pbms_pkg::S_TDATA_W-1:0] s_tdata,
    // [2:0] func
    input  logic [pbms_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] bit_out, [5:1] dimension_out, [6] status
    output logic [pbms_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int DW    = $clog2(MAX_DIM + 1);
    localparam int CW    = (DW > pbms_pkg::NDIM_W) ? DW : pbms_pkg::NDIM_W;
    localparam int TOTAL = MAX_DIM * MAX_DIM;
    localparam int PW    = $clog2(TOTAL);
    localparam logic [CW-1:0] MAX_DIM_C = CW'(MAX_DIM);
    localparam logic [PW-1:0] LAST_POS  = PW'(TOTAL - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_FILL,
        ST_GROW_INIT,
        ST_GROW,
        ST_GROW_WR,
        ST_RM,
        ST_RM_WR,
        ST_ACCESS,
        ST_RD_WAIT,
        ST_DONE
    } state_t;

    state_t                              state_reg, state_next;
    logic [pbms_pkg::FUNC_W-1:0]         func_reg, func_next;
    logic [pbms_pkg::NDIM_W-1:0]         nd_reg, nd_next;
    logic [pbms_pkg::INDEX_W-1:0]        row_reg, row_next;
    logic [pbms_pkg::INDEX_W-1:0]        col_reg, col_next;
    logic                                val_reg, val_next;
    logic [DW-1:0]                       dim_reg, dim_next;
    logic [DW-1:0]                       x_reg, x_next;
    logic [DW-1:0]                       y_reg, y_next;
    logic [PW-1:0]                       pos_new_reg, pos_new_next;
    logic [PW-1:0]                       pos_old_reg, pos_old_next;
    logic [PW-1:0]                       prod_reg, prod_next;
    logic                                bit_reg, bit_next;
    logic                                status_reg, status_next;
    logic                                m_tvalid_reg, m_tvalid_next;
    logic [pbms_pkg::M_TDATA_W-1:0]      m_tdata_reg, m_tdata_next;

    logic          ram_we;
    logic [PW-1:0] ram_waddr;
    logic          ram_wdata;
    logic [PW-1:0] ram_raddr;
    logic          ram_rdata;

    logic [DW-1:0]   mul_a;
    logic [2*DW-1:0] mul_p;
    logic [CW-1:0]   dim_c, row_c, col_c, nd_c;
    logic [PW-1:0]   acc_addr;
    logic [DW-1:0]   dim_m1;

    pbms_bit_ram #(
        .DEPTH (TOTAL)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign dim_c    = CW'(dim_reg);
    assign row_c    = CW'(row_reg);
    assign col_c    = CW'(col_reg);
    assign nd_c     = CW'(nd_reg);
    assign dim_m1   = dim_reg - DW'(1);
    assign mul_a    = (func_reg == pbms_pkg::OP_GROW) ? dim_reg : DW'(row_reg);
    assign mul_p    = (2*DW)'(mul_a) * (2*DW)'(dim_reg);
    assign acc_addr = prod_reg + PW'(col_reg);

    always_comb begin
        state_next    = state_reg;
        func_next     = func_reg;
        nd_next       = nd_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        val_next      = val_reg;
        dim_next      = dim_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        pos_new_next  = pos_new_reg;
        pos_old_next  = pos_old_reg;
        prod_next     = prod_reg;
        bit_next      = bit_reg;
        status_next   = status_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        ram_we        = 1'b0;
        ram_waddr     = pos_new_reg;
        ram_wdata     = 1'b1;
        ram_raddr     = pos_old_reg;

        unique case (state_reg) inside
            ST_IDLE: begin
                if (s_tvalid) begin
                    func_next  = s_tuser[2:0];
                    nd_next    = s_tdata[4:0];
                    row_next   = s_tdata[8:5];
                    col_next   = s_tdata[12:9];
                    val_next   = s_tdata[13];
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                bit_next    = 1'b0;
                status_next = pbms_pkg::STATUS_DONE;
                prod_next   = mul_p[PW-1:0];
                state_next  = ST_DONE;
                unique case (func_reg) inside
                    pbms_pkg::OP_SIZE: begin
                        if (nd_c > MAX_DIM_C) begin
                            status_next = pbms_pkg::STATUS_IGNORED;
                        end else begin
                            dim_next     = DW'(nd_reg);
                            pos_new_next = '0;
                            state_next   = ST_FILL;
                        end
                    end
                    pbms_pkg::OP_GROW: begin
                        if (dim_c >= MAX_DIM_C) begin
                            status_next = pbms_pkg::STATUS_IGNORED;
                        end else begin
                            x_next     = dim_reg;
                            y_next     = dim_reg;
                            state_next = ST_GROW_INIT;
                        end
                    end
                    pbms_pkg::OP_REMOVE: begin
                        if (row_c >= dim_c) begin
                            status_next = pbms_pkg::STATUS_IGNORED;
                        end else begin
                            x_next       = '0;
                            y_next       = '0;
                            pos_new_next = '0;
                            pos_old_next = '0;
                            state_next   = ST_RM;
                        end
                    end
                    pbms_pkg::OP_READ, pbms_pkg::OP_WRITE: begin
                        if (row_c >= dim_c || col_c >= dim_c) begin
                            status_next = pbms_pkg::STATUS_IGNORED;
                        end else begin
                            state_next = ST_ACCESS;
                        end
                    end
                    default: begin
                        status_next = pbms_pkg::STATUS_IGNORED;
                    end
                endcase
            end
            ST_FILL: begin
                ram_we = 1'b1;
                if (pos_new_reg == LAST_POS) begin
                    state_next = ST_DONE;
                end else begin
                    pos_new_next = pos_new_reg + PW'(1);
                end
            end
            ST_GROW_INIT: begin
                pos_new_next = prod_reg + PW'(dim_reg) + PW'(dim_reg);
                pos_old_next = prod_reg - PW'(1);
                state_next   = ST_GROW;
            end
            ST_GROW, ST_GROW_WR: begin
                if (state_reg == ST_GROW && x_reg < dim_reg && y_reg < dim_reg) begin
                    state_next = ST_GROW_WR;
                end else begin
                    ram_we = 1'b1;
                    if (state_reg == ST_GROW_WR) begin
                        ram_wdata    = ram_rdata;
                        pos_old_next = pos_old_reg - PW'(1);
                    end
                    state_next = ST_GROW;
                    if (x_reg == '0 && y_reg == '0) begin
                        dim_next   = dim_reg + DW'(1);
                        state_next = ST_DONE;
                    end else begin
                        pos_new_next = pos_new_reg - PW'(1);
                        if (y_reg == '0) begin
                            y_next = dim_reg;
                            x_next = x_reg - DW'(1);
                        end else begin
                            y_next = y_reg - DW'(1);
                        end
                    end
                end
            end
            ST_RM, ST_RM_WR: begin
                if (state_reg == ST_RM && CW'(x_reg) != row_c && CW'(y_reg) != row_c) begin
                    state_next = ST_RM_WR;
                end else begin
                    if (state_reg == ST_RM_WR) begin
                        ram_we       = 1'b1;
                        ram_wdata    = ram_rdata;
                        pos_new_next = pos_new_reg + PW'(1);
                    end
                    state_next = ST_RM;
                    if (x_reg == dim_m1 && y_reg == dim_m1) begin
                        dim_next   = dim_m1;
                        state_next = ST_DONE;
                    end else begin
                        pos_old_next = pos_old_reg + PW'(1);
                        if (y_reg == dim_m1) begin
                            y_next = '0;
                            x_next = x_reg + DW'(1);
                        end else begin
                            y_next = y_reg + DW'(1);
                        end
                    end
                end
            end
            ST_ACCESS: begin
                ram_raddr = acc_addr;
                ram_waddr = acc_addr;
                ram_wdata = val_reg;
                if (func_reg == pbms_pkg::OP_WRITE) begin
                    ram_we     = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_RD_WAIT;
                end
            end
            ST_RD_WAIT: begin
                bit_next   = ram_rdata;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, status_reg,
                                     dim_c[pbms_pkg::DIMOUT_W-1:0], bit_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            dim_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            dim_reg      <= dim_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        func_reg    <= func_next;
        nd_reg      <= nd_next;
        row_reg     <= row_next;
        col_reg     <= col_next;
        val_reg     <= val_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        pos_new_reg <= pos_new_next;
        pos_old_reg <= pos_old_next;
        prod_reg    <= prod_next;
        bit_reg     <= bit_next;
        status_reg  <= status_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_dim_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        dim_c <= MAX_DIM_C)
        else $error("dimension beyond MAX_DIM");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item accepted while an operation is starting");

    a_grow_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_GROW_WR) |-> (pos_old_reg <= pos_new_reg))
        else $error("grow copy would overwrite an unread bit");

    a_remove_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RM_WR) |-> (pos_new_reg <= pos_old_reg))
        else $error("remove copy would overwrite an unread bit");

    a_bit_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> (m_tdata[6] == pbms_pkg::STATUS_DONE))
        else $error("bit returned for an ignored operation");

endmodule

[sv/pbms_bit_ram.sv]
// One-bit-wide memory with one write port and one registered read port.
module pbms_bit_ram #(
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic                     wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic                     rdata
);

    logic mem [DEPTH];
    logic rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
